// ===== hdl/swssd_pkg.sv =====
// Package with the shared constants, types and tables of the steady-state detector.
`default_nettype none
package swssd_pkg;

    // Sizing of the window and of the samples.
    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 40;
    localparam int IDX_W       = $clog2(MAX_WINDOW);
    localparam int WIN_W       = $clog2(MAX_WINDOW + 1);
    localparam int WLEN_W      = 7;
    localparam int SUM_W       = SAMPLE_BITS + IDX_W;
    localparam int WSUM_W      = SAMPLE_BITS + 2 * IDX_W;
    localparam int PROD_W      = WSUM_W + WIN_W;
    localparam int DEN_W       = 4 * WIN_W;

    // Fixed-point result format and the divider.
    localparam int CRIT_W   = 40;
    localparam int FRAC_W   = 16;
    localparam int DVS_W    = 64;
    localparam int DVD_W    = DVS_W + FRAC_W;
    localparam logic [CRIT_W-1:0] CRIT_CAP = {1'b0, {(CRIT_W-1){1'b1}}};
    localparam logic [6:0] PCT_SCALE = 7'd100;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_SLOPE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_IOPS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERCENT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT      = 3'd4;

    // Stream widths.
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 48;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAP,
        OP_RD_OLD,
        OP_UPD,
        OP_UPD2,
        OP_SL_MUL,
        OP_SL_DIFF,
        OP_DIV_MEAN,
        OP_SL_PCT,
        OP_DV_RD,
        OP_DV_CMP,
        OP_DIV_Q,
        OP_FIN
    } t_op;

    // Kind of result built at the end of an item.
    typedef enum logic [1:0] {
        K_FILL,
        K_FROZEN,
        K_EVAL,
        K_FAULT
    } t_kind;

    typedef struct packed {
        t_op   op;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic attained;
        logic full_next;
        logic mode_slope;
        logic pct;
        logic div_busy;
        logic q_zero;
        logic sum_zero;
        logic idx_last;
        logic out_free;
    } t_sts;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDOLD,
        S_UPD,
        S_UPD2,
        S_SL_MUL,
        S_SL_DIFF,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_SL_PCT,
        S_DV_RD,
        S_DV_CMP,
        S_DV_END,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FIN
    } t_state;

    // Regression denominator n^2(n^2-1)/12 for every window length.
    typedef logic [DEN_W-1:0] t_den_tbl [0:MAX_WINDOW];

    function automatic t_den_tbl f_den_tbl();
        t_den_tbl tbl;
        longint   v;
        for (int i = 0; i <= MAX_WINDOW; i++) begin
            v      = longint'(i) * longint'(i);
            tbl[i] = DEN_W'((v * (v - 1)) / 12);
        end
        return tbl;
    endfunction

    localparam t_den_tbl DEN_TBL = f_den_tbl();

endpackage
`default_nettype wire

// ===== hdl/swssd_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module swssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hdl/swssd_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module swssd_div
    import swssd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic      [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W:0]   rem2;
    logic             ge;

    // Shift in the next dividend bit and try the subtraction.
    always_comb begin
        rem2 = {r_rem, r_dvd[DVD_W-1]};
        ge   = (rem2 >= {1'b0, r_dvs});
    end

    // Step counter is control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DVD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= ge ? DVS_W'(rem2 - {1'b0, r_dvs}) : rem2[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== hdl/swssd_dp.sv =====
// Datapath: configuration, window state, sample RAM, arithmetic and output register.
`default_nettype none
module swssd_dp
    import swssd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic [SAMPLE_BITS-1:0] i_iops,
    input  wire logic [SAMPLE_BITS-1:0] i_bw,
    input  wire t_cmd                   i_cmd,
    output t_sts                        o_sts,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [OUT_DATA_W-1:0]       o_out_data
);

    // Configuration registers.
    logic               r_mode_slope;
    logic               r_use_iops;
    logic               r_pct;
    logic [WLEN_W-1:0]  r_win_len;
    logic [CRIT_W-1:0]  r_limit;

    // Window state.
    logic [IDX_W-1:0]       r_wpos;
    logic [WIN_W-1:0]       r_fill;
    logic [SUM_W-1:0]       r_sum;
    logic [WSUM_W-1:0]      r_wsum;
    logic                   r_attained;
    logic [SAMPLE_BITS-1:0] r_y;
    logic                   r_filling;
    logic [SUM_W-1:0]       r_prod;

    // Evaluation working registers.
    logic [IDX_W-1:0]  r_idx;
    logic [SUM_W-1:0]  r_mx;
    logic [PROD_W-1:0] r_pa;
    logic [PROD_W-1:0] r_pb;
    logic [PROD_W-1:0] r_num;
    logic              r_neg;
    logic [DVS_W-1:0]  r_nume;
    logic [DVS_W-1:0]  r_deno;

    // Output register.
    logic                  r_ovalid;
    logic                  r_o_att;
    logic                  r_o_full;
    logic [CRIT_W-1:0]     r_o_crit;
    logic                  r_o_fault;

    logic [WIN_W-1:0]       n;
    logic [2*WIN_W-1:0]     sx;
    logic [DEN_W-1:0]       den;
    logic                   clr_win;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                   wpos_wrap;
    logic                   filling_now;
    logic [SUM_W-1:0]       ny;
    logic [SUM_W-1:0]       dev;
    logic                   div_start;
    logic [DVD_W-1:0]       div_dvd;
    logic [DVS_W-1:0]       div_dvs;
    logic                   div_busy;
    logic [DVD_W-1:0]       div_quo;
    logic [CRIT_W-2:0]      mag;
    logic                   sat;
    logic                   eval_neg;
    logic [CRIT_W-1:0]      eval_crit;

    // Clamped window length and length-dependent constants.
    always_comb begin
        if (r_win_len < WLEN_W'(2)) begin
            n = WIN_W'(2);
        end else if (r_win_len > WLEN_W'(MAX_WINDOW)) begin
            n = WIN_W'(MAX_WINDOW);
        end else begin
            n = WIN_W'(r_win_len);
        end
        sx  = ((2*WIN_W)'(n) * (2*WIN_W)'(n - 1'b1)) >> 1;
        den = DEN_TBL[n];
    end

    assign clr_win = i_cfg_we && (i_cfg_idx == REG_USE_IOPS || i_cfg_idx == REG_WINDOW_LEN);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_slope <= 1'b0;
            r_use_iops   <= 1'b1;
            r_pct        <= 1'b0;
            r_win_len    <= WLEN_W'(MAX_WINDOW);
            r_limit      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE_SLOPE: r_mode_slope <= i_cfg_data[0];
                REG_USE_IOPS:   r_use_iops   <= i_cfg_data[0];
                REG_PERCENT:    r_pct        <= i_cfg_data[0];
                REG_WINDOW_LEN: r_win_len    <= i_cfg_data[WLEN_W-1:0];
                REG_LIMIT:      r_limit      <= i_cfg_data[CRIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample RAM holding the ring.
    assign ram_we    = (i_cmd.op == OP_UPD);
    assign ram_raddr = (i_cmd.op == OP_DV_RD) ? r_idx : r_wpos;

    swssd_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wpos),
        .i_wdata (r_y),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        wpos_wrap   = ({1'b0, r_wpos} == (n - 1'b1));
        filling_now = (r_fill < n);
        ny          = SUM_W'(n) * SUM_W'(ram_rdata);
        dev         = (ny >= r_sum) ? (ny - r_sum) : (r_sum - ny);
    end

    // Window state: ring position, fill count, running and weighted sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos     <= '0;
            r_fill     <= '0;
            r_sum      <= '0;
            r_wsum     <= '0;
            r_attained <= 1'b0;
        end else if (clr_win) begin
            r_wpos <= '0;
            r_fill <= '0;
            r_sum  <= '0;
            r_wsum <= '0;
        end else begin
            if (i_cmd.op == OP_UPD) begin
                r_wpos <= wpos_wrap ? '0 : r_wpos + 1'b1;
                if (filling_now) begin
                    r_sum <= r_sum + SUM_W'(r_y);
                end else begin
                    r_sum <= r_sum - SUM_W'(ram_rdata) + SUM_W'(r_y);
                end
            end
            if (i_cmd.op == OP_UPD2) begin
                if (r_filling) begin
                    r_wsum <= r_wsum + WSUM_W'(r_prod);
                    r_fill <= r_fill + 1'b1;
                end else begin
                    r_wsum <= r_wsum - WSUM_W'(r_sum) + WSUM_W'(r_prod);
                end
            end
            if (i_cmd.op == OP_FIN && i_cmd.kind == K_EVAL && {1'b0, mag} < r_limit) begin
                r_attained <= 1'b1;
            end
        end
    end

    // Working registers of one item.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CAP: begin
                r_y   <= r_use_iops ? i_iops : i_bw;
                r_neg <= 1'b0;
            end
            OP_UPD: begin
                r_filling <= filling_now;
                r_prod    <= SUM_W'(filling_now ? r_fill : n) * SUM_W'(r_y);
            end
            OP_UPD2: begin
                r_idx <= '0;
                r_mx  <= '0;
            end
            OP_SL_MUL: begin
                r_pa <= PROD_W'(n) * PROD_W'(r_wsum);
                r_pb <= PROD_W'(sx) * PROD_W'(r_sum);
            end
            OP_SL_DIFF: begin
                if (r_pa >= r_pb) begin
                    r_num <= r_pa - r_pb;
                    r_neg <= 1'b0;
                end else begin
                    r_num <= r_pb - r_pa;
                    r_neg <= 1'b1;
                end
            end
            OP_SL_PCT: begin
                r_nume <= DVS_W'(PCT_SCALE) * DVS_W'(r_num);
                r_deno <= DVS_W'(den) * DVS_W'(div_quo[SAMPLE_BITS-1:0]);
            end
            OP_DV_CMP: begin
                if (dev > r_mx) begin
                    r_mx <= dev;
                end
                r_idx <= r_idx + 1'b1;
            end
            default: ;
        endcase
    end

    // Divider operand selection.
    always_comb begin
        div_start = (i_cmd.op == OP_DIV_MEAN) || (i_cmd.op == OP_DIV_Q);
        if (i_cmd.op == OP_DIV_MEAN) begin
            div_dvd = DVD_W'(r_sum);
            div_dvs = DVS_W'(n);
        end else if (r_mode_slope && r_pct) begin
            div_dvd = {r_nume, {FRAC_W{1'b0}}};
            div_dvs = r_deno;
        end else if (r_mode_slope) begin
            div_dvd = DVD_W'({r_num, {FRAC_W{1'b0}}});
            div_dvs = DVS_W'(den);
        end else if (r_pct) begin
            div_dvd = {DVS_W'(PCT_SCALE) * DVS_W'(r_mx), {FRAC_W{1'b0}}};
            div_dvs = DVS_W'(r_sum);
        end else begin
            div_dvd = DVD_W'({r_mx, {FRAC_W{1'b0}}});
            div_dvs = DVS_W'(n);
        end
    end

    swssd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    // Saturated magnitude and signed criterion.
    always_comb begin
        sat       = (div_quo[DVD_W-1:CRIT_W-1] != '0);
        mag       = sat ? CRIT_CAP[CRIT_W-2:0] : div_quo[CRIT_W-2:0];
        eval_neg  = r_neg && (mag != '0);
        eval_crit = eval_neg ? (CRIT_W'(0) - {1'b0, mag}) : {1'b0, mag};
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_FIN) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FIN) begin
            unique case (i_cmd.kind)
                K_FILL: begin
                    r_o_att   <= r_attained;
                    r_o_full  <= 1'b0;
                    r_o_crit  <= '0;
                    r_o_fault <= 1'b0;
                end
                K_FROZEN: begin
                    r_o_att   <= 1'b1;
                    r_o_full  <= 1'b0;
                    r_o_crit  <= '0;
                    r_o_fault <= 1'b0;
                end
                K_EVAL: begin
                    r_o_att   <= r_attained || ({1'b0, mag} < r_limit);
                    r_o_full  <= 1'b1;
                    r_o_crit  <= eval_crit;
                    r_o_fault <= 1'b0;
                end
                K_FAULT: begin
                    r_o_att   <= r_attained;
                    r_o_full  <= 1'b1;
                    r_o_crit  <= CRIT_CAP;
                    r_o_fault <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = OUT_DATA_W'({r_o_fault, r_o_crit, r_o_full, r_o_att});

    // Status toward the controller.
    always_comb begin
        o_sts.attained   = r_attained;
        o_sts.full_next  = !r_filling || ((r_fill + 1'b1) == n);
        o_sts.mode_slope = r_mode_slope;
        o_sts.pct        = r_pct;
        o_sts.div_busy   = div_busy;
        o_sts.q_zero     = (div_quo == '0);
        o_sts.sum_zero   = (r_sum == '0);
        o_sts.idx_last   = ({1'b0, r_idx} == (n - 1'b1));
        o_sts.out_free   = !r_ovalid || i_out_ready;
    end

endmodule
`default_nettype wire

// ===== hdl/swssd_ctrl.sv =====
// Controller state machine sequencing the datapath for one sample.
`default_nettype none
module swssd_ctrl
    import swssd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    t_kind  r_kind;
    t_kind  n_kind;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_FILL;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        o_cmd.op   = OP_NONE;
        o_cmd.kind = r_kind;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_CAP;
                    if (i_sts.attained) begin
                        n_kind  = K_FROZEN;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_RDOLD;
                    end
                end
            end
            S_RDOLD: begin
                o_cmd.op = OP_RD_OLD;
                n_state  = S_UPD;
            end
            S_UPD: begin
                o_cmd.op = OP_UPD;
                n_state  = S_UPD2;
            end
            S_UPD2: begin
                o_cmd.op = OP_UPD2;
                if (!i_sts.full_next) begin
                    n_kind  = K_FILL;
                    n_state = S_FIN;
                end else if (i_sts.mode_slope) begin
                    n_state = S_SL_MUL;
                end else begin
                    n_state = S_DV_RD;
                end
            end
            S_SL_MUL: begin
                o_cmd.op = OP_SL_MUL;
                n_state  = S_SL_DIFF;
            end
            S_SL_DIFF: begin
                o_cmd.op = OP_SL_DIFF;
                n_state  = i_sts.pct ? S_MEAN_GO : S_DIV_GO;
            end
            S_MEAN_GO: begin
                o_cmd.op = OP_DIV_MEAN;
                n_state  = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (!i_sts.div_busy) begin
                    if (i_sts.q_zero) begin
                        n_kind  = K_FAULT;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SL_PCT;
                    end
                end
            end
            S_SL_PCT: begin
                o_cmd.op = OP_SL_PCT;
                n_state  = S_DIV_GO;
            end
            S_DV_RD: begin
                o_cmd.op = OP_DV_RD;
                n_state  = S_DV_CMP;
            end
            S_DV_CMP: begin
                o_cmd.op = OP_DV_CMP;
                n_state  = i_sts.idx_last ? S_DV_END : S_DV_RD;
            end
            S_DV_END: begin
                if (i_sts.pct && i_sts.sum_zero) begin
                    n_kind  = K_FAULT;
                    n_state = S_FIN;
                end else begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                o_cmd.op = OP_DIV_Q;
                n_state  = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_kind  = K_EVAL;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_FIN;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/sliding_window_steady_state_detector_unit.sv =====
// Processing time is set by the bit-serial divider and, in deviation mode, by the walk of the
// sample RAM that reads and compares each window entry in turn; one sample is processed at a
// time, and the result waits in an output register.
// Synchronous active-low reset clears the window, the sticky flag, the configuration registers
// and the output valid flag to their defaults; no clearing pass is needed.
`default_nettype none
module sliding_window_steady_state_detector_unit
    import swssd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // iops_sample[39:0], bw_sample[79:40]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata,   // attained[0], window_full[1],
                                                  // criterion[41:2], mean_zero_fault[42], zero pad
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Controller.
    swssd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath.
    swssd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_iops      (s_tdata[SAMPLE_BITS-1:0]),
        .i_bw        (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_out_data  (m_tdata)
    );

endmodule
`default_nettype wire

// ===== hdl/swssd_chk.sv =====
// Port-level checker for the steady-state detector and its bind statement.
`default_nettype none
module swssd_chk
    import swssd_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [IN_DATA_W-1:0]  s_tdata,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic                  i_cfg_we,
    input wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // A pending result stays offered until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transaction");

    // One sample at a time: input is refused right after a transaction.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // An unevaluated window reports a zero criterion and no fault.
    a_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tdata[1] |-> (m_tdata[41:2] == '0) && !m_tdata[42])
        else $error("criterion without full window");

    // A zero-mean fault saturates the criterion.
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[42] |-> (m_tdata[41:2] == CRIT_CAP) && m_tdata[1])
        else $error("fault without saturated criterion");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind sliding_window_steady_state_detector_unit swssd_chk u_chk (.*);
`default_nettype wire
